// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the link steering block.
// Depends on nothing; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TLCRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define TLCRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TLCRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TLCRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/tlcrs_pkg.sv =====
// Package of the link steering block: field widths, register map, shared types.
// Used by the channel interfaces, the serial divider and the top level.
package tlcrs_pkg;

    localparam int FT_W       = 57;
    localparam int NOW_W      = 40;
    localparam int RATE_W     = 17;
    localparam int QUEUE_W    = 24;
    localparam int RTT_W      = 10;
    localparam int ALPHA_W    = 10;
    localparam int ALPHA_FRAC = 8;
    localparam int PKT_W      = 16;
    localparam int SUM_W      = 25;
    localparam int DEN_W      = 24;
    localparam int WHOLE_W    = 41;
    localparam int PROD_W     = 67;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 4;

    localparam logic [6:0] RATE_MULT = 7'd125;
    localparam logic [FT_W-1:0] FT_MAX = '1;

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_HRTT  = 2'd1;
    localparam logic [1:0] REG_LRTT  = 2'd2;
    localparam logic [1:0] REG_PKT   = 2'd3;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = 10'd192;
    localparam logic [RTT_W-1:0]   RTT_RST   = 10'd5;
    localparam logic [PKT_W-1:0]   PKT_RST   = 16'd1400;

    typedef struct packed {
        logic start;
        logic step;
    } t_div_ctl;

    function automatic logic [FT_W-1:0] sat_add(input logic [FT_W-1:0] a,
                                                input logic [FT_W-1:0] b);
        logic [FT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[FT_W] ? FT_MAX : s[FT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/tlcrs_if.sv =====
// Valid/ready channel interfaces for the link steering block: input and result.
// Depends on tlcrs_pkg for field widths.
interface tlcrs_in_if;
    logic                              valid;
    logic                              ready;
    logic [tlcrs_pkg::NOW_W-1:0]       now_ms;
    logic [tlcrs_pkg::RATE_W-1:0]      hbc_rate_mbps;
    logic [tlcrs_pkg::QUEUE_W-1:0]     hbc_queue_bytes;
    logic [tlcrs_pkg::RATE_W-1:0]      llc_rate_mbps;
    logic [tlcrs_pkg::QUEUE_W-1:0]     llc_queue_bytes;
    logic                              links_known;

    modport source (output valid, now_ms, hbc_rate_mbps, hbc_queue_bytes,
                    llc_rate_mbps, llc_queue_bytes, links_known, input ready);
    modport sink   (input valid, now_ms, hbc_rate_mbps, hbc_queue_bytes,
                    llc_rate_mbps, llc_queue_bytes, links_known, output ready);
endinterface

interface tlcrs_out_if;
    logic                          valid;
    logic                          ready;
    logic                          chosen_link;
    logic [tlcrs_pkg::FT_W-1:0]    finish_time;
    logic                          delay_saturated;

    modport source (output valid, chosen_link, finish_time, delay_saturated,
                    input ready);
    modport sink   (input valid, chosen_link, finish_time, delay_saturated,
                    output ready);
endinterface

// ===== hw/rtl/two_link_cost_reward_steering.sv =====
// Top level of the two-link cost/reward steering block.
// Depends on tlcrs_pkg, tlcrs_if, tlcrs_div_serial and assert_macros.svh.
//
// Usage:
//   i_in carries one packet's metrics per transfer; o_out returns one decision
//   per transfer (chosen link, stored finish time, saturation flag). The APB
//   port holds alpha_q8, both link RTTs and the packet size at byte addresses
//   0, 4, 8 and 12; pready is always high and reads return the register.
//   With both links known an item passes through the two bit-serial dividers
//   working side by side, a step that forms the finish times, the shift-add
//   alpha multiplier and a decision step. A new item is taken only once the
//   previous one has left the decision step. An item with links unknown skips
//   the dividers and the multiplier and goes straight to the decision step.
//   The result register frees the input side: a new item is taken while an
//   earlier result waits; if the receiver stalls, the decision cycle holds
//   until the result register empties and the stored finish time is updated
//   only when the result is loaded.
//   Reset clears the stored finish time, loads the register defaults and
//   empties the result register.
`include "assert_macros.svh"
module two_link_cost_reward_steering #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tlcrs_in_if.sink                          i_in,
    tlcrs_out_if.source                       o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlcrs_pkg::ADDR_W-1:0]      paddr,
    input  logic [tlcrs_pkg::DATA_W-1:0]      pwdata,
    output logic [tlcrs_pkg::DATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int NUM_W  = tlcrs_pkg::SUM_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int FIX_SH = tlcrs_pkg::FT_W - FRAC_BITS;
    localparam int FT_W   = tlcrs_pkg::FT_W;
    localparam int PROD_W = tlcrs_pkg::PROD_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;

    function automatic logic [FT_W-1:0] to_fixed(
        input logic [tlcrs_pkg::WHOLE_W-1:0] whole);
        logic [FT_W-1:0] ext;
        ext = FT_W'(whole);
        if ((ext >> FIX_SH) != '0) return tlcrs_pkg::FT_MAX;
        return ext << FRAC_BITS;
    endfunction

    logic [2:0]                       r_state, n_state;
    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    logic [tlcrs_pkg::ALPHA_W-1:0]    r_alpha;
    logic [tlcrs_pkg::RTT_W-1:0]      r_hrtt;
    logic [tlcrs_pkg::RTT_W-1:0]      r_lrtt;
    logic [tlcrs_pkg::PKT_W-1:0]      r_pkt;
    logic [FT_W-1:0]                  r_prev, n_prev;
    logic                             r_out_valid;
    logic                             r_out_link;
    logic [FT_W-1:0]                  r_out_ft;
    logic                             r_out_sat;
    logic                             r_known;
    logic                             r_sat_h;
    logic                             r_sat_l;
    logic [FT_W-1:0]                  r_base_h;
    logic [FT_W-1:0]                  r_base_l;
    logic [FT_W-1:0]                  r_c_hbc;
    logic [FT_W-1:0]                  r_c_llc;
    logic [FT_W-1:0]                  r_m;
    logic [FT_W-1:0]                  r_diff;
    logic                             r_hgt;
    logic [PROD_W-1:0]                r_prod;
    logic [PROD_W-1:0]                r_mcand;
    logic [tlcrs_pkg::ALPHA_W-1:0]    r_alpha_sh;

    logic                             in_acc;
    logic                             cfg_wr;
    logic                             slot_free;
    logic                             dec_fire;
    logic                             choice;
    logic [FT_W-1:0]                  pick;
    logic [tlcrs_pkg::SUM_W-1:0]      sum_h, sum_l;
    logic [tlcrs_pkg::DEN_W-1:0]      den_h, den_l;
    logic [NUM_W-1:0]                 quo_h, quo_l;
    logic [FT_W-1:0]                  hdel, ldel;
    tlcrs_pkg::t_div_ctl              div_ctl;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign i_in.ready  = i_rst_n && (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign slot_free   = !r_out_valid || o_out.ready;
    assign dec_fire    = (r_state == S_DEC) && slot_free;

    assign sum_h = tlcrs_pkg::SUM_W'(r_pkt) + tlcrs_pkg::SUM_W'(i_in.hbc_queue_bytes);
    assign sum_l = tlcrs_pkg::SUM_W'(r_pkt) + tlcrs_pkg::SUM_W'(i_in.llc_queue_bytes);
    assign den_h = tlcrs_pkg::DEN_W'(i_in.hbc_rate_mbps)
                 * tlcrs_pkg::DEN_W'(tlcrs_pkg::RATE_MULT);
    assign den_l = tlcrs_pkg::DEN_W'(i_in.llc_rate_mbps)
                 * tlcrs_pkg::DEN_W'(tlcrs_pkg::RATE_MULT);

    assign div_ctl.start = in_acc;
    assign div_ctl.step  = (r_state == S_DIV);

    tlcrs_div_serial #(.NUM_W(NUM_W)) u_div_hbc (
        .i_clk (i_clk),
        .i_ctl (div_ctl),
        .i_num ({sum_h, {FRAC_BITS{1'b0}}}),
        .i_den (den_h),
        .o_quo (quo_h)
    );

    tlcrs_div_serial #(.NUM_W(NUM_W)) u_div_llc (
        .i_clk (i_clk),
        .i_ctl (div_ctl),
        .i_num ({sum_l, {FRAC_BITS{1'b0}}}),
        .i_den (den_l),
        .o_quo (quo_l)
    );

    assign hdel = r_sat_h ? tlcrs_pkg::FT_MAX : FT_W'(quo_h);
    assign ldel = r_sat_l ? tlcrs_pkg::FT_MAX : FT_W'(quo_l);

    assign choice = r_known && r_hgt
                 && (PROD_W'({r_diff, {tlcrs_pkg::ALPHA_FRAC{1'b0}}}) > r_prod);
    assign pick   = choice ? r_c_llc : r_c_hbc;
    assign n_prev = (r_known && (pick > r_prev)) ? pick : r_prev;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (in_acc) n_state = i_in.links_known ? S_DIV : S_DEC;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) n_state = S_FIN;
            end
            S_FIN: begin
                n_cnt   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(tlcrs_pkg::ALPHA_W - 1)) n_state = S_DEC;
            end
            S_DEC: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_alpha     <= tlcrs_pkg::ALPHA_RST;
            r_hrtt      <= tlcrs_pkg::RTT_RST;
            r_lrtt      <= tlcrs_pkg::RTT_RST;
            r_pkt       <= tlcrs_pkg::PKT_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (dec_fire) begin
                r_out_valid <= 1'b1;
                r_prev      <= n_prev;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    tlcrs_pkg::REG_ALPHA: r_alpha <= pwdata[tlcrs_pkg::ALPHA_W-1:0];
                    tlcrs_pkg::REG_HRTT:  r_hrtt  <= pwdata[tlcrs_pkg::RTT_W-1:0];
                    tlcrs_pkg::REG_LRTT:  r_lrtt  <= pwdata[tlcrs_pkg::RTT_W-1:0];
                    tlcrs_pkg::REG_PKT:   r_pkt   <= pwdata[tlcrs_pkg::PKT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_known  <= i_in.links_known;
            r_sat_h  <= (i_in.hbc_rate_mbps == '0);
            r_sat_l  <= (i_in.llc_rate_mbps == '0);
            r_base_h <= to_fixed(tlcrs_pkg::WHOLE_W'(i_in.now_ms)
                                 + tlcrs_pkg::WHOLE_W'(r_hrtt));
            r_base_l <= to_fixed(tlcrs_pkg::WHOLE_W'(i_in.now_ms)
                                 + tlcrs_pkg::WHOLE_W'(r_lrtt));
        end
        if (r_state == S_FIN) begin
            r_c_hbc    <= tlcrs_pkg::sat_add(r_base_h, hdel);
            r_c_llc    <= tlcrs_pkg::sat_add(r_base_l, ldel);
            r_mcand    <= PROD_W'(ldel);
            r_alpha_sh <= r_alpha;
            r_prod     <= '0;
        end
        if (r_state == S_MUL) begin
            if (r_alpha_sh[0]) r_prod <= r_prod + r_mcand;
            r_mcand    <= r_mcand << 1;
            r_alpha_sh <= r_alpha_sh >> 1;
            r_m        <= (r_prev > r_c_llc) ? r_prev : r_c_llc;
            r_hgt      <= r_c_hbc > r_m;
            r_diff     <= r_c_hbc - r_m;
        end
        if (dec_fire) begin
            r_out_link <= choice;
            r_out_ft   <= n_prev;
            r_out_sat  <= r_known && (r_sat_h || r_sat_l);
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            tlcrs_pkg::REG_ALPHA: prdata = tlcrs_pkg::DATA_W'(r_alpha);
            tlcrs_pkg::REG_HRTT:  prdata = tlcrs_pkg::DATA_W'(r_hrtt);
            tlcrs_pkg::REG_LRTT:  prdata = tlcrs_pkg::DATA_W'(r_lrtt);
            tlcrs_pkg::REG_PKT:   prdata = tlcrs_pkg::DATA_W'(r_pkt);
            default:              prdata = '0;
        endcase
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.chosen_link     = r_out_link;
    assign o_out.finish_time     = r_out_ft;
    assign o_out.delay_saturated = r_out_sat;

    `TLCRS_ASSERT_NXT(a_prev_monotonic, i_clk, i_rst_n, 1'b1, r_prev >= $past(r_prev))
    `TLCRS_ASSERT_NXT(a_unknown_keeps_prev, i_clk, i_rst_n, dec_fire && !r_known, r_prev == $past(r_prev))
    `TLCRS_ASSERT_IMP(a_result_from_decision, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DEC)

endmodule

// ===== hw/rtl/tlcrs_div_serial.sv =====
// Restoring divider, one quotient bit per cycle while step is held, shifted into the dividend register.
// Depends on tlcrs_pkg for the divisor width and the control struct.
module tlcrs_div_serial #(
    parameter int NUM_W = 41
) (
    input  logic                          i_clk,
    input  tlcrs_pkg::t_div_ctl           i_ctl,
    input  logic [NUM_W-1:0]              i_num,
    input  logic [tlcrs_pkg::DEN_W-1:0]   i_den,
    output logic [NUM_W-1:0]              o_quo
);

    logic [NUM_W-1:0]              r_acc;
    logic [tlcrs_pkg::DEN_W-1:0]   r_rem;
    logic [tlcrs_pkg::DEN_W-1:0]   r_den;
    logic [tlcrs_pkg::DEN_W:0]     part;
    logic [tlcrs_pkg::DEN_W:0]     diff;
    logic                          ge;

    assign part = {r_rem, r_acc[NUM_W-1]};
    assign diff = part - {1'b0, r_den};
    assign ge   = part >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (i_ctl.step) begin
            r_acc <= {r_acc[NUM_W-2:0], ge};
            r_rem <= ge ? diff[tlcrs_pkg::DEN_W-1:0] : part[tlcrs_pkg::DEN_W-1:0];
        end
    end

    assign o_quo = r_acc;

endmodule

// ===== tb/sv/tlcrs_decision_checker.sv =====
`timescale 1ns / 1ps
// Decision checker for two_link_cost_reward_steering: watches both channels and the APB port,
// predicts each steering decision from its own registers and stored finish time, and compares.
// Depends on tlcrs_pkg and the tlcrs_in_if / tlcrs_out_if channel interfaces.
module tlcrs_decision_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tlcrs_in_if                          i_in_mon,
    tlcrs_out_if                         i_out_mon,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tlcrs_pkg::ADDR_W-1:0] paddr,
    input  logic [tlcrs_pkg::DATA_W-1:0] pwdata,
    input  logic [tlcrs_pkg::DATA_W-1:0] prdata,
    input  logic                         pready,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_decisions,
    output int                           o_llc_picks,
    output int                           o_saturations
);
    import tlcrs_pkg::*;

    typedef logic [127:0] wide_t;

    typedef struct packed {
        logic            chosen_link;
        logic [FT_W-1:0] finish_time;
        logic            delay_saturated;
    } decision_t;

    localparam wide_t FT_LIMIT  = (wide_t'(1) << FT_W) - 1;
    localparam wide_t FRAC_MASK = (wide_t'(1) << ALPHA_FRAC) - 1;

    decision_t          decision_q[$];
    logic [ALPHA_W-1:0] alpha_q8;
    logic [RTT_W-1:0]   hbc_rtt;
    logic [RTT_W-1:0]   llc_rtt;
    logic [PKT_W-1:0]   pkt_bytes;
    logic [FT_W-1:0]    last_finish;
    int                 mismatches;
    int                 decisions;
    int                 llc_picks;
    int                 saturations;

    function automatic wide_t service_time(input logic [RATE_W-1:0]  rate,
                                           input logic [QUEUE_W-1:0] queue);
        wide_t bytes_fx;
        if (rate == '0) begin
            return FT_LIMIT;
        end
        bytes_fx = (wide_t'(pkt_bytes) + wide_t'(queue)) << FRAC_BITS;
        return bytes_fx / (wide_t'(rate) * wide_t'(RATE_MULT));
    endfunction

    function automatic wide_t finish_at(input logic [NOW_W-1:0] now,
                                        input logic [RTT_W-1:0] rtt,
                                        input wide_t            delay);
        wide_t whole;
        wide_t base;
        whole = wide_t'(now) + wide_t'(rtt);
        base  = (whole > (FT_LIMIT >> FRAC_BITS)) ? FT_LIMIT : (whole << FRAC_BITS);
        return (base + delay > FT_LIMIT) ? FT_LIMIT : base + delay;
    endfunction

    function automatic decision_t predict_decision(input logic [NOW_W-1:0]   now,
                                                   input logic [RATE_W-1:0]  hbc_rate,
                                                   input logic [QUEUE_W-1:0] hbc_queue,
                                                   input logic [RATE_W-1:0]  llc_rate,
                                                   input logic [QUEUE_W-1:0] llc_queue,
                                                   input logic               known);
        decision_t d;
        wide_t     llc_delay;
        wide_t     hbc_finish;
        wide_t     llc_finish;
        wide_t     latest;
        wide_t     threshold;
        wide_t     pick;
        d.chosen_link     = 1'b0;
        d.finish_time     = last_finish;
        d.delay_saturated = 1'b0;
        if (!known) begin
            return d;
        end
        llc_delay  = service_time(llc_rate, llc_queue);
        hbc_finish = finish_at(now, hbc_rtt, service_time(hbc_rate, hbc_queue));
        llc_finish = finish_at(now, llc_rtt, llc_delay);
        d.delay_saturated = (hbc_rate == '0) || (llc_rate == '0);
        latest = (wide_t'(last_finish) > llc_finish) ? wide_t'(last_finish) : llc_finish;
        if (hbc_finish > latest) begin
            threshold = wide_t'(alpha_q8) * (llc_delay >> ALPHA_FRAC)
                      + ((wide_t'(alpha_q8) * (llc_delay & FRAC_MASK)) >> ALPHA_FRAC);
            if (hbc_finish - latest > threshold) begin
                d.chosen_link = 1'b1;
            end
        end
        pick = d.chosen_link ? llc_finish : hbc_finish;
        if (pick > wide_t'(last_finish)) begin
            d.finish_time = pick[FT_W-1:0];
        end
        return d;
    endfunction

    function automatic logic [DATA_W-1:0] register_value(input logic [1:0] index);
        case (index)
            REG_ALPHA: return DATA_W'(alpha_q8);
            REG_HRTT:  return DATA_W'(hbc_rtt);
            REG_LRTT:  return DATA_W'(llc_rtt);
            default:   return DATA_W'(pkt_bytes);
        endcase
    endfunction

    task automatic note_failure(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        if (mismatches < 10) begin
            $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        decision_t observed;
        decision_t wanted;
        decision_t predicted;
        if (!i_rst_n) begin
            alpha_q8    <= ALPHA_RST;
            hbc_rtt     <= RTT_RST;
            llc_rtt     <= RTT_RST;
            pkt_bytes   <= PKT_RST;
            last_finish <= '0;
            decision_q.delete();
            mismatches  = 0;
            decisions   = 0;
            llc_picks   = 0;
            saturations = 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[ADDR_W-1:2])
                        REG_ALPHA: alpha_q8  <= pwdata[ALPHA_W-1:0];
                        REG_HRTT:  hbc_rtt   <= pwdata[RTT_W-1:0];
                        REG_LRTT:  llc_rtt   <= pwdata[RTT_W-1:0];
                        default:   pkt_bytes <= pwdata[PKT_W-1:0];
                    endcase
                end else if (prdata !== register_value(paddr[ADDR_W-1:2])) begin
                    note_failure($sformatf("register read at %0h", paddr),
                                 64'(register_value(paddr[ADDR_W-1:2])), 64'(prdata));
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                observed.chosen_link     = i_out_mon.chosen_link;
                observed.finish_time     = i_out_mon.finish_time;
                observed.delay_saturated = i_out_mon.delay_saturated;
                if (decision_q.size() == 0) begin
                    note_failure("decision with none pending", '0, 64'(observed.finish_time));
                end else begin
                    wanted = decision_q.pop_front();
                    decisions++;
                    if (observed.chosen_link !== wanted.chosen_link) begin
                        note_failure($sformatf("decision %0d chosen_link", decisions),
                                     64'(wanted.chosen_link), 64'(observed.chosen_link));
                    end
                    if (observed.finish_time !== wanted.finish_time) begin
                        note_failure($sformatf("decision %0d finish_time", decisions),
                                     64'(wanted.finish_time), 64'(observed.finish_time));
                    end
                    if (observed.delay_saturated !== wanted.delay_saturated) begin
                        note_failure($sformatf("decision %0d delay_saturated", decisions),
                                     64'(wanted.delay_saturated),
                                     64'(observed.delay_saturated));
                    end
                    llc_picks   += wanted.chosen_link;
                    saturations += wanted.delay_saturated;
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                predicted = predict_decision(i_in_mon.now_ms, i_in_mon.hbc_rate_mbps,
                                             i_in_mon.hbc_queue_bytes, i_in_mon.llc_rate_mbps,
                                             i_in_mon.llc_queue_bytes, i_in_mon.links_known);
                decision_q.push_back(predicted);
                last_finish <= predicted.finish_time;
            end
        end
        o_fail_count  <= mismatches;
        o_pending     <= decision_q.size();
        o_decisions   <= decisions;
        o_llc_picks   <= llc_picks;
        o_saturations <= saturations;
    end

endmodule

// ===== tb/sv/two_link_cost_reward_steering_test.sv =====
`timescale 1ns / 1ps
// Top of the two_link_cost_reward_steering testbench: packet stream, APB register settings,
// result back-pressure and the verdict. Depends on tlcrs_pkg, the channel interfaces,
// the block itself and tlcrs_decision_checker, which does all prediction and comparison.
module two_link_cost_reward_steering_test;
    import tlcrs_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int LATENCY     = FRAC_BITS + 38;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 183;
    localparam logic [RATE_W-1:0] RATE_MAX = 17'd100000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                decisions;
    int                llc_picks;
    int                saturations;
    int                cycles = 0;
    int                sent = 0;
    int                settings = 0;
    logic [NOW_W-1:0]  clock_ms;

    tlcrs_in_if  in_ch();
    tlcrs_out_if out_ch();

    always #2 i_clk = ~i_clk;

    two_link_cost_reward_steering #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tlcrs_decision_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) decision_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_decisions   (decisions),
        .o_llc_picks   (llc_picks),
        .o_saturations (saturations)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("two_link_cost_reward_steering test failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_span(input int bits);
        int width;
        width = $urandom_range(0, bits);
        return (width == 0) ? 32'd0 : ($urandom & (32'hFFFF_FFFF >> (32 - width)));
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        logic [31:0] r;
        r = rand_span(RATE_W);
        return (r > RATE_MAX) ? RATE_W'($urandom_range(65536, RATE_MAX)) : RATE_W'(r);
    endfunction

    task automatic apb_access(input logic write, input logic [1:0] index,
                              input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_registers();
        apb_access(1'b0, REG_ALPHA, '0);
        apb_access(1'b0, REG_HRTT, '0);
        apb_access(1'b0, REG_LRTT, '0);
        apb_access(1'b0, REG_PKT, '0);
    endtask

    task automatic configure(input logic [ALPHA_W-1:0] alpha, input logic [RTT_W-1:0] hrtt,
                             input logic [RTT_W-1:0] lrtt, input logic [PKT_W-1:0] pkt);
        apb_access(1'b1, REG_ALPHA, DATA_W'(alpha));
        apb_access(1'b1, REG_HRTT, DATA_W'(hrtt));
        apb_access(1'b1, REG_LRTT, DATA_W'(lrtt));
        apb_access(1'b1, REG_PKT, DATA_W'(pkt));
        read_registers();
        settings++;
    endtask

    // drain every pending decision, then let the pipeline go quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic send_item(input logic [NOW_W-1:0] now, input logic [RATE_W-1:0] hrate,
                             input logic [QUEUE_W-1:0] hqueue, input logic [RATE_W-1:0] lrate,
                             input logic [QUEUE_W-1:0] lqueue, input logic known);
        int gap;
        gap = (((sent / 64) % 4) == 0) ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.now_ms          <= now;
        in_ch.hbc_rate_mbps   <= hrate;
        in_ch.hbc_queue_bytes <= hqueue;
        in_ch.llc_rate_mbps   <= lrate;
        in_ch.llc_queue_bytes <= lqueue;
        in_ch.links_known     <= known;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    initial begin : receiver
        int stall;
        int taken;
        taken = 0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken == 300) begin
                stall = 400;
            end else if (taken == 800) begin
                stall = 250;
            end else begin
                stall = (((taken / 50) % 4) == 1) ? 0 : $urandom_range(0, 4);
            end
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            taken++;
        end
    end

    initial begin : stimulus
        int                 phase;
        int                 n;
        logic [RATE_W-1:0]  hr;
        logic [RATE_W-1:0]  lr;
        logic [31:0]        step;
        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.now_ms          <= '0;
        in_ch.hbc_rate_mbps   <= '0;
        in_ch.hbc_queue_bytes <= '0;
        in_ch.llc_rate_mbps   <= '0;
        in_ch.llc_queue_bytes <= '0;
        in_ch.links_known     <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        read_registers();

        send_item('1, RATE_MAX, '1, RATE_MAX, '1, 1'b0);
        send_item('0, '0, '0, '0, '0, 1'b0);
        send_item(40'd0, 17'd1, '0, 17'd1, '0, 1'b1);
        send_item(40'd10, 17'd1, '1, RATE_MAX, '0, 1'b1);
        send_item(40'd20, RATE_MAX, '0, 17'd1, '1, 1'b1);
        send_item(40'd30, '0, 24'd5000, 17'd1000, '0, 1'b1);
        send_item(40'd40, 17'd1000, '0, '0, 24'd5000, 1'b1);
        send_item(40'd50, RATE_MAX, '1, RATE_MAX, '1, 1'b1);
        send_item(40'd60, 17'd10, 24'd20000, 17'd100, '0, 1'b1);
        send_item(40'd100, 17'd100, 24'd1000, 17'd100, '0, 1'b1);
        send_item(40'd110, 17'd100, 24'd3000, 17'd100, '0, 1'b1);
        send_item(40'd200, 17'd1, '1, 17'd1, '1, 1'b1);

        clock_ms = NOW_W'(32'd1 << 20) + NOW_W'($urandom_range(0, 1 << 20));
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                settle();
                case (phase)
                    1: configure('0, '0, '0, '0);
                    2: configure('1, '1, '1, '1);
                    default: configure(ALPHA_W'($urandom_range(0, 1023)),
                                       RTT_W'($urandom_range(0, 1023)),
                                       RTT_W'($urandom_range(0, 1023)),
                                       PKT_W'($urandom_range(1, 65535)));
                endcase
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(NOW_W'({$urandom, $urandom}), pick_rate(), QUEUE_W'($urandom),
                              pick_rate(), QUEUE_W'($urandom), 1'b0);
                end else begin
                    step = ($urandom_range(0, 19) == 0) ? rand_span(18) : rand_span(12);
                    clock_ms = clock_ms + NOW_W'(step);
                    hr = pick_rate();
                    lr = pick_rate();
                    if (hr == '0 && lr == '0) begin
                        lr = 17'd1;
                    end
                    send_item(clock_ms, hr, QUEUE_W'(rand_span(QUEUE_W)), lr,
                              QUEUE_W'(rand_span(QUEUE_W)), 1'b1);
                end
            end
        end

        // stored finish time only ever rises: saturating cases go last
        send_item('1, '0, '1, 17'd1000, '0, 1'b1);
        send_item('1, RATE_MAX, '0, RATE_MAX, '0, 1'b1);
        send_item(40'd5, '0, '0, '0, '0, 1'b1);
        send_item(40'd1000, 17'd500, 24'd100, 17'd500, 24'd100, 1'b1);
        send_item(40'd2000, 17'd500, 24'd100, 17'd500, 24'd100, 1'b0);

        settle();
        $display("%0d items sent, %0d decisions checked over %0d register settings",
                 sent, decisions, settings + 1);
        $display("%0d went to the low-latency link, %0d had a saturated delay",
                 llc_picks, saturations);
        if (pending != 0) begin
            $display("%0d decisions never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("two_link_cost_reward_steering test passed");
        end else begin
            $display("two_link_cost_reward_steering test failed");
        end
        $finish;
    end

endmodule
